// ----- rtl/base36_bit_permute_word_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the base-36 word decoder
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BASE36_BIT_PERMUTE_WORD_DECODER_MACROS_SVH
`define BASE36_BIT_PERMUTE_WORD_DECODER_MACROS_SVH

// Same-cycle implication
`define B36_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define B36_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/b36bpw_pkg.sv -----
// ----------------------------------------------------------------------------
// b36bpw_pkg
// Types, constants and helper functions of the base-36 word decoder.
// ----------------------------------------------------------------------------
package b36bpw_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_DIGITS = 7;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned BCNT_W      = 2;
    localparam int unsigned DIGIT_W     = 9;

    localparam logic [POS_W-1:0]  LAST_DIGIT = POS_W'(GROUP_DIGITS - 1);
    localparam logic [BCNT_W-1:0] LAST_BYTE  = 2'd3;

    // APB register map
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam logic        REG_SEED    = 1'b0;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    // 'A' - 10: offset of the letter formula
    localparam logic [DIGIT_W-1:0] LETTER_OFS = 9'd55;

    // Bit k of a group moves to bit PERM[k] of the word
    localparam logic [4:0] PERM [WORD_W] = '{
        5'd18, 5'd29, 5'd7,  5'd25, 5'd15, 5'd31, 5'd22, 5'd27,
        5'd9,  5'd26, 5'd3,  5'd13, 5'd19, 5'd14, 5'd20, 5'd11,
        5'd5,  5'd2,  5'd23, 5'd16, 5'd10, 5'd24, 5'd28, 5'd17,
        5'd6,  5'd30, 5'd0,  5'd21, 5'd12, 5'd8,  5'd4,  5'd1
    };

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       word_last;
        logic       message_last;
    } out_t;

    // Word handed from the group logic to the byte serializer
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic              msg_last;
    } word_req_t;

    // Digit value of a character, signed; non-digits use the letter formula
    function automatic logic [DIGIT_W-1:0] char_digit(input logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = {1'b0, c} - {1'b0, CHAR_ZERO};
        end else begin
            d = {1'b0, c} - LETTER_OFS;
        end
        return d;
    endfunction

    // 36^pos modulo 2^32
    function automatic logic [WORD_W-1:0] digit_weight(input logic [POS_W-1:0] pos);
        logic [WORD_W-1:0] w;
        unique case (pos)
            3'd0:    w = 32'd1;
            3'd1:    w = 32'd36;
            3'd2:    w = 32'd1296;
            3'd3:    w = 32'd46656;
            3'd4:    w = 32'd1679616;
            3'd5:    w = 32'd60466176;
            3'd6:    w = 32'd2176782336;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] permute_bits(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < WORD_W; k++) begin
            r[PERM[k]] = v[k];
        end
        return r;
    endfunction

endpackage

// ----- rtl/b36bpw_serializer.sv -----
// ----------------------------------------------------------------------------
// b36bpw_serializer
// Holds one decoded word and sends it as four bytes, least significant first.
// ----------------------------------------------------------------------------
`include "base36_bit_permute_word_decoder_macros.svh"

module b36bpw_serializer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b36bpw_pkg::word_req_t ld,
    output logic                  ld_free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b36bpw_pkg::out_t      m_data
);

    logic                                 vld_reg;
    logic [b36bpw_pkg::BCNT_W-1:0]        cnt_reg;
    logic [b36bpw_pkg::WORD_W-1:0]        word_reg;
    logic                                 msg_last_reg;
    logic                                 final_take;

    // Word slot frees when its last byte is taken
    assign final_take = vld_reg && m_ready && (cnt_reg == b36bpw_pkg::LAST_BYTE);
    assign ld_free    = !vld_reg || final_take;

    // Control: load a new word or advance the byte count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (ld.valid) begin
            vld_reg <= 1'b1;
            cnt_reg <= '0;
        end else if (vld_reg && m_ready) begin
            if (cnt_reg == b36bpw_pkg::LAST_BYTE) begin
                vld_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Payload: capture the word on load
    always_ff @(posedge aclk) begin
        if (ld.valid) begin
            word_reg     <= ld.word;
            msg_last_reg <= ld.msg_last;
        end
    end

    // Drive the current byte
    assign m_valid              = vld_reg;
    assign m_data.out_byte      = word_reg[cnt_reg*b36bpw_pkg::BYTE_W +: b36bpw_pkg::BYTE_W];
    assign m_data.word_last     = (cnt_reg == b36bpw_pkg::LAST_BYTE);
    assign m_data.message_last  = (cnt_reg == b36bpw_pkg::LAST_BYTE) && msg_last_reg;

    `B36_ASSERT_NOW(a_load_when_free, ld.valid, ld_free, "word loaded over a busy slot")
    `B36_ASSERT_NEXT(a_load_starts, ld.valid, m_valid && (cnt_reg == '0),
        "loaded word does not start at its first byte")
    `B36_ASSERT_NEXT(a_drain_ends, final_take && !ld.valid, !m_valid,
        "slot stays busy after its last byte")

endmodule

// ----- rtl/base36_bit_permute_word_decoder.sv -----
// ----------------------------------------------------------------------------
// base36_bit_permute_word_decoder
// Base-36 text to word decoder with fixed bit permutation and seed removal.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one character request per cycle (in_char,
//   in_last). Seven characters, least significant digit first, form one
//   group; in_last closes a group early, missing digits count as zero.
//   Each closed group is permuted, has the seed subtracted and leaves on
//   m_valid/m_ready/m_data as four bytes, LSB first, word_last on the fourth
//   and message_last on the fourth byte of a word closed by in_last.
//   The seed register sits at APB addresses 0 to 3; pready is always high.
//   A closing request is captured in the input register, then its word in
//   the serializer's word register, which drives the first byte. Throughput:
//   one character per cycle while s_ready is high, set by the digit
//   multiply-accumulate; the byte serializer keeps up with full groups while
//   m_ready is high. Groups closed early by in_last take one word slot each.
//   When the receiver stalls, the current byte holds and s_ready drops once
//   the input register holds a closing character and the word slot is busy.
//   Reset clears the seed, the group accumulator and all valid flags.
// ----------------------------------------------------------------------------
`include "base36_bit_permute_word_decoder_macros.svh"

module base36_bit_permute_word_decoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Character input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  b36bpw_pkg::in_t                       s_data,
    // Byte output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output b36bpw_pkg::out_t                      m_data,
    // Configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [b36bpw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [b36bpw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [b36bpw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    logic [b36bpw_pkg::WORD_W-1:0]  seed_reg;
    logic                           in_vld_reg;
    b36bpw_pkg::in_t                in_reg;
    logic [b36bpw_pkg::WORD_W-1:0]  acc_reg;
    logic [b36bpw_pkg::WORD_W-1:0]  acc_next;
    logic [b36bpw_pkg::POS_W-1:0]   pos_reg;
    logic [b36bpw_pkg::POS_W-1:0]   pos_next;
    logic [b36bpw_pkg::DIGIT_W-1:0] digit;
    logic [b36bpw_pkg::WORD_W-1:0]  digit_ext;
    logic [b36bpw_pkg::WORD_W-1:0]  acc_sum;
    logic                           complete;
    logic                           proc_go;
    logic                           ld_free;
    b36bpw_pkg::word_req_t          word_req;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[b36bpw_pkg::APB_ADDR_W-1] == b36bpw_pkg::REG_SEED) ?
                    seed_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[b36bpw_pkg::APB_ADDR_W-1] == b36bpw_pkg::REG_SEED) begin
            seed_reg <= pwdata;
        end
    end

    // Process the held character when its word, if any, can be placed
    assign complete = (pos_reg == b36bpw_pkg::LAST_DIGIT) || in_reg.in_last;
    assign proc_go  = in_vld_reg && (!complete || ld_free);
    assign s_ready  = !in_vld_reg || proc_go;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (proc_go) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Digit multiply-accumulate
    assign digit     = b36bpw_pkg::char_digit(in_reg.in_char);
    assign digit_ext = {{(b36bpw_pkg::WORD_W - b36bpw_pkg::DIGIT_W){digit[b36bpw_pkg::DIGIT_W-1]}},
                        digit};
    assign acc_sum   = acc_reg + digit_ext * b36bpw_pkg::digit_weight(pos_reg);

    // Restart the group once a word is produced
    always_comb begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (proc_go) begin
            if (complete) begin
                acc_next = '0;
                pos_next = '0;
            end else begin
                acc_next = acc_sum;
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            pos_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
        end
    end

    // Permute the closed group and remove the seed
    assign word_req.valid    = proc_go && complete;
    assign word_req.word     = b36bpw_pkg::permute_bits(acc_sum) - seed_reg;
    assign word_req.msg_last = in_reg.in_last;

    b36bpw_serializer u_ser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ld      (word_req),
        .ld_free (ld_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `B36_ASSERT_NOW(a_pos_range, 1'b1, pos_reg != 3'd7, "digit position beyond a group")
    `B36_ASSERT_NEXT(a_group_restart, proc_go && complete, (acc_reg == '0) && (pos_reg == '0),
        "group state not cleared after a word")
    `B36_ASSERT_NOW(a_empty_ready, !in_vld_reg, s_ready, "empty input register refuses a request")

endmodule
